>>> rtl/core/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types and constants for the rgb fade/blink remote controller:
// channel level and step encodings, timing scales and remote command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfb_pkg;

   typedef logic [7:0]  level_type;
   typedef logic [1:0]  step_type;
   typedef logic [4:0]  speed_type;
   typedef logic [11:0] blink_wait_type;
   typedef logic [7:0]  code_type;

   localparam int NUM_CHANNELS = 3;

   localparam level_type LEVEL_MIN = 8'd0;
   localparam level_type LEVEL_MAX = 8'd255;

   // two's complement step: up is +1, down is -1
   localparam step_type STEP_ZERO = 2'd0;
   localparam step_type STEP_UP   = 2'd1;
   localparam step_type STEP_DOWN = 2'd3;

   localparam speed_type      SPEED_1     = 5'd1;
   localparam speed_type      SPEED_3     = 5'd3;
   localparam speed_type      SPEED_5     = 5'd5;
   localparam speed_type      SPEED_10    = 5'd10;
   localparam speed_type      SPEED_25    = 5'd25;
   localparam speed_type      SPEED_RESET = SPEED_10;
   localparam blink_wait_type BLINK_SCALE = 12'd100;

   localparam code_type CODE_NONE        = 8'd0;
   localparam code_type CODE_HALT        = 8'd28;
   localparam code_type CODE_FADE_TOGGLE = 8'd25;
   localparam code_type CODE_CLEAR_LEVEL = 8'd22;
   localparam code_type CODE_RANDOMIZE   = 8'd13;
   localparam code_type CODE_CLEAR_STEP  = 8'd24;
   localparam code_type CODE_STEP_RED    = 8'd8;
   localparam code_type CODE_STEP_GREEN  = 8'd82;
   localparam code_type CODE_STEP_BLUE   = 8'd90;
   localparam code_type CODE_LEVEL_RED   = 8'd7;
   localparam code_type CODE_LEVEL_GREEN = 8'd21;
   localparam code_type CODE_LEVEL_BLUE  = 8'd9;
   localparam code_type CODE_SPEED_1     = 8'd68;
   localparam code_type CODE_SPEED_3     = 8'd67;
   localparam code_type CODE_SPEED_5     = 8'd69;
   localparam code_type CODE_SPEED_10    = 8'd70;
   localparam code_type CODE_SPEED_25    = 8'd71;
   localparam code_type CODE_BLINK_TOGGLE = 8'd64;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

endpackage

>>> rtl/core/rgb_fade_blink_remote_controller_top.sv
// ----------------------------------------------------------------------------
// rgb_fade_blink_remote_controller_top
// Three-channel rgb effect controller fed by millisecond ticks and decoded
// remote command bytes. Each accepted transaction updates the channel state
// in one pass and yields one result with the three levels, the fade and blink
// mode flags and an unknown-command flag. One transaction is taken every
// clock cycle as long as no result waits untaken; its result is presented
// from the output register on the following cycle, and a new transaction is
// accepted while that result waits, as long as it is taken in the same
// cycle. Throughput is limited only by the single output register draining.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_fade_blink_remote_controller_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_ir_code,
   input  logic       req_repeat_flag,
   input  logic [7:0] req_rand_red,
   input  logic [7:0] req_rand_green,
   input  logic [7:0] req_rand_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_fade_on,
   output logic       rsp_blink_on,
   output logic       rsp_unknown_code
);

   rfb_pkg::level_type      level_ff [rfb_pkg::NUM_CHANNELS];
   rfb_pkg::level_type      level_in [rfb_pkg::NUM_CHANNELS];
   rfb_pkg::step_type       step_ff  [rfb_pkg::NUM_CHANNELS];
   rfb_pkg::step_type       step_in  [rfb_pkg::NUM_CHANNELS];
   rfb_pkg::speed_type      speed_ff, speed_in;
   logic                    fade_mode_ff, fade_mode_in;
   logic                    blink_mode_ff, blink_mode_in;
   rfb_pkg::speed_type      fade_wait_ff, fade_wait_in;
   rfb_pkg::blink_wait_type blink_wait_ff, blink_wait_in;
   logic                    unknown_in;

   logic                    rsp_valid_ff;
   rfb_pkg::level_type      rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                    rsp_fade_ff, rsp_blink_ff, rsp_unknown_ff;

   logic                    accept;
   rfb_pkg::code_type       code;
   rfb_pkg::level_type      rand_level [rfb_pkg::NUM_CHANNELS];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // repeat frames count as the ignored code
   assign code = req_repeat_flag ? rfb_pkg::CODE_NONE : req_ir_code;

   assign rand_level[rfb_pkg::CH_RED]   = req_rand_red;
   assign rand_level[rfb_pkg::CH_GREEN] = req_rand_green;
   assign rand_level[rfb_pkg::CH_BLUE]  = req_rand_blue;

   always_comb begin
      for (int i = 0; i < rfb_pkg::NUM_CHANNELS; i++) begin
         level_in[i] = level_ff[i];
         step_in[i]  = step_ff[i];
      end
      speed_in      = speed_ff;
      fade_mode_in  = fade_mode_ff;
      blink_mode_in = blink_mode_ff;
      fade_wait_in  = fade_wait_ff;
      blink_wait_in = blink_wait_ff;
      unknown_in    = 1'b0;

      if (!req_cmd) begin
         // both waits count down and hold at zero
         if (fade_wait_ff != '0) begin
            fade_wait_in = fade_wait_ff - 5'd1;
         end
         if (blink_wait_ff != '0) begin
            blink_wait_in = blink_wait_ff - 12'd1;
         end
         if (fade_mode_ff) begin
            if (fade_wait_in == '0) begin
               for (int i = 0; i < rfb_pkg::NUM_CHANNELS; i++) begin
                  if (step_ff[i] == rfb_pkg::STEP_UP) begin
                     if (level_ff[i] == rfb_pkg::LEVEL_MAX) begin
                        step_in[i] = rfb_pkg::STEP_DOWN;
                     end else begin
                        level_in[i] = level_ff[i] + 8'd1;
                     end
                  end else if (step_ff[i] != rfb_pkg::STEP_ZERO) begin
                     if (level_ff[i] == rfb_pkg::LEVEL_MIN) begin
                        step_in[i] = rfb_pkg::STEP_UP;
                     end else begin
                        level_in[i] = level_ff[i] - 8'd1;
                     end
                  end
               end
               fade_wait_in = speed_ff;
            end
         end else if (blink_mode_ff) begin
            if (blink_wait_in == '0) begin
               for (int i = 0; i < rfb_pkg::NUM_CHANNELS; i++) begin
                  if (step_ff[i] != rfb_pkg::STEP_ZERO) begin
                     level_in[i] = (level_ff[i] != rfb_pkg::LEVEL_MIN) ?
                                   rfb_pkg::LEVEL_MIN : rfb_pkg::LEVEL_MAX;
                  end
               end
               blink_wait_in = 12'(speed_ff) * rfb_pkg::BLINK_SCALE;
            end
         end
      end else begin
         case (code)
            rfb_pkg::CODE_NONE: begin
            end
            rfb_pkg::CODE_HALT: begin
               fade_mode_in  = 1'b0;
               blink_mode_in = 1'b0;
               for (int i = 0; i < rfb_pkg::NUM_CHANNELS; i++) begin
                  level_in[i] = rfb_pkg::LEVEL_MIN;
                  step_in[i]  = rfb_pkg::STEP_UP;
               end
            end
            rfb_pkg::CODE_FADE_TOGGLE: begin
               fade_mode_in = !fade_mode_ff;
            end
            rfb_pkg::CODE_BLINK_TOGGLE: begin
               blink_mode_in = !blink_mode_ff;
            end
            rfb_pkg::CODE_CLEAR_LEVEL: begin
               for (int i = 0; i < rfb_pkg::NUM_CHANNELS; i++) begin
                  level_in[i] = rfb_pkg::LEVEL_MIN;
               end
            end
            rfb_pkg::CODE_RANDOMIZE: begin
               for (int i = 0; i < rfb_pkg::NUM_CHANNELS; i++) begin
                  level_in[i] = rand_level[i];
               end
            end
            rfb_pkg::CODE_CLEAR_STEP: begin
               for (int i = 0; i < rfb_pkg::NUM_CHANNELS; i++) begin
                  step_in[i] = rfb_pkg::STEP_ZERO;
               end
            end
            rfb_pkg::CODE_STEP_RED: begin
               step_in[rfb_pkg::CH_RED] =
                  (step_ff[rfb_pkg::CH_RED] != rfb_pkg::STEP_ZERO) ?
                  rfb_pkg::STEP_ZERO : rfb_pkg::STEP_UP;
            end
            rfb_pkg::CODE_STEP_GREEN: begin
               step_in[rfb_pkg::CH_GREEN] =
                  (step_ff[rfb_pkg::CH_GREEN] != rfb_pkg::STEP_ZERO) ?
                  rfb_pkg::STEP_ZERO : rfb_pkg::STEP_UP;
            end
            rfb_pkg::CODE_STEP_BLUE: begin
               step_in[rfb_pkg::CH_BLUE] =
                  (step_ff[rfb_pkg::CH_BLUE] != rfb_pkg::STEP_ZERO) ?
                  rfb_pkg::STEP_ZERO : rfb_pkg::STEP_UP;
            end
            rfb_pkg::CODE_LEVEL_RED: begin
               level_in[rfb_pkg::CH_RED] =
                  (level_ff[rfb_pkg::CH_RED] != rfb_pkg::LEVEL_MIN) ?
                  rfb_pkg::LEVEL_MIN : rfb_pkg::LEVEL_MAX;
            end
            rfb_pkg::CODE_LEVEL_GREEN: begin
               level_in[rfb_pkg::CH_GREEN] =
                  (level_ff[rfb_pkg::CH_GREEN] != rfb_pkg::LEVEL_MIN) ?
                  rfb_pkg::LEVEL_MIN : rfb_pkg::LEVEL_MAX;
            end
            rfb_pkg::CODE_LEVEL_BLUE: begin
               level_in[rfb_pkg::CH_BLUE] =
                  (level_ff[rfb_pkg::CH_BLUE] != rfb_pkg::LEVEL_MIN) ?
                  rfb_pkg::LEVEL_MIN : rfb_pkg::LEVEL_MAX;
            end
            rfb_pkg::CODE_SPEED_1:  speed_in = rfb_pkg::SPEED_1;
            rfb_pkg::CODE_SPEED_3:  speed_in = rfb_pkg::SPEED_3;
            rfb_pkg::CODE_SPEED_5:  speed_in = rfb_pkg::SPEED_5;
            rfb_pkg::CODE_SPEED_10: speed_in = rfb_pkg::SPEED_10;
            rfb_pkg::CODE_SPEED_25: speed_in = rfb_pkg::SPEED_25;
            default: begin
               unknown_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rfb_pkg::NUM_CHANNELS; i++) begin
            level_ff[i] <= rfb_pkg::LEVEL_MIN;
            step_ff[i]  <= rfb_pkg::STEP_UP;
         end
         speed_ff      <= rfb_pkg::SPEED_RESET;
         fade_mode_ff  <= 1'b0;
         blink_mode_ff <= 1'b0;
         fade_wait_ff  <= '0;
         blink_wait_ff <= '0;
      end else if (accept) begin
         for (int i = 0; i < rfb_pkg::NUM_CHANNELS; i++) begin
            level_ff[i] <= level_in[i];
            step_ff[i]  <= step_in[i];
         end
         speed_ff      <= speed_in;
         fade_mode_ff  <= fade_mode_in;
         blink_mode_ff <= blink_mode_in;
         fade_wait_ff  <= fade_wait_in;
         blink_wait_ff <= blink_wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, loaded with the state this transaction leaves behind
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_red_ff     <= level_in[rfb_pkg::CH_RED];
         rsp_green_ff   <= level_in[rfb_pkg::CH_GREEN];
         rsp_blue_ff    <= level_in[rfb_pkg::CH_BLUE];
         rsp_fade_ff    <= fade_mode_in;
         rsp_blink_ff   <= blink_mode_in;
         rsp_unknown_ff <= unknown_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = rsp_red_ff;
   assign rsp_green        = rsp_green_ff;
   assign rsp_blue         = rsp_blue_ff;
   assign rsp_fade_on      = rsp_fade_ff;
   assign rsp_blink_on     = rsp_blink_ff;
   assign rsp_unknown_code = rsp_unknown_ff;

endmodule
